### rtl/sat_pkg.sv
`timescale 1ns / 1ps

package sat_pkg;

  // Command codes carried in the cmd field of an input word.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_OFFSET = 2'd1;
  localparam logic [1:0] CMD_ADDR   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_LOADED = 2'd0;
  localparam logic [1:0] STAT_OK     = 2'd1;
  localparam logic [1:0] STAT_MISS   = 2'd2;
  localparam logic [1:0] STAT_TAIL   = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 8'd1;

  // Input word layout, lowest field first.
  localparam int unsigned IN_CMD_LSB  = 0;
  localparam int unsigned IN_IDX_LSB  = 2;
  localparam int unsigned IN_VS_LSB   = 6;
  localparam int unsigned IN_VA_LSB   = 38;
  localparam int unsigned IN_RS_LSB   = 70;
  localparam int unsigned IN_RP_LSB   = 102;
  localparam int unsigned IN_OFF_LSB  = 134;
  localparam int unsigned IN_ADDR_LSB = 167;
  localparam int unsigned IN_W        = 232;

  // Output word layout: status, then value, padded to whole bytes.
  localparam int unsigned OUT_W = 72;

  typedef struct packed {
    logic [31:0] fptr;
    logic [31:0] fsize;
    logic [31:0] vaddr;
    logic [31:0] vsize;
  } sat_entry_t;

  localparam int unsigned ENTRY_W = $bits(sat_entry_t);

endpackage

### rtl/section_address_translation_top.sv
`timescale 1ns / 1ps
// A load word goes from acceptance straight to result forming; a query first scans the
// entries in use, unless an address lies below the image base, then forms its result.
// Throughput: one word at a time; the next word is accepted once the previous result sits in
// the output register.
// The scan rate is set by the single read port of the section table, one entry per cycle.
// Reset clears the control state and both configuration registers; the table is not cleared.

module section_address_translation_top #(
  parameter int unsigned MAX_SECTIONS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input words.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata from bit 0 up: cmd, entry_index, virtual size, virtual address, raw size,
  // raw pointer, file offset, address, one zero pad bit.
  input  logic [sat_pkg::IN_W-1:0]       s_axis_tdata_i,
  // Result words.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata from bit 0 up: status, value, six zero pad bits.
  output logic [sat_pkg::OUT_W-1:0]      m_axis_tdata_o,
  // Configuration writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sat_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [63:0]                    cfg_data_i
);

  import sat_pkg::*;

  localparam int unsigned AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  // Controller states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FORM = 2'd2;

  // Fields of the incoming word.
  logic [1:0]  in_cmd;
  logic [3:0]  in_entry_index;
  logic [32:0] in_foff;
  logic [63:0] in_address;
  sat_entry_t  in_entry;

  assign in_cmd         = s_axis_tdata_i[IN_CMD_LSB +: 2];
  assign in_entry_index = s_axis_tdata_i[IN_IDX_LSB +: 4];
  assign in_entry.vsize = s_axis_tdata_i[IN_VS_LSB +: 32];
  assign in_entry.vaddr = s_axis_tdata_i[IN_VA_LSB +: 32];
  assign in_entry.fsize = s_axis_tdata_i[IN_RS_LSB +: 32];
  assign in_entry.fptr  = s_axis_tdata_i[IN_RP_LSB +: 32];
  assign in_foff        = s_axis_tdata_i[IN_OFF_LSB +: 33];
  assign in_address     = s_axis_tdata_i[IN_ADDR_LSB +: 64];

  // Configuration registers. Writes are to arrive only while the block is idle; the block itself does not enforce this.
  logic [63:0] image_base_q;
  logic [4:0]  section_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_base_q    <= '0;
      section_count_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_IMAGE_BASE) begin
        image_base_q <= cfg_data_i;
      end else if (cfg_index_i == REG_SECTION_COUNT) begin
        section_count_q <= cfg_data_i[4:0];
      end
    end
  end

  // A count beyond the table depth is clamped to the depth.
  logic [4:0] n_used;
  assign n_used = (32'(section_count_q) > MAX_SECTIONS) ? 5'(MAX_SECTIONS) : section_count_q;

  // Controller and datapath registers.
  logic [1:0]  state_q, state_d;
  logic [4:0]  rd_idx_q, rd_idx_d;    // next table entry to read
  logic        chk_vld_q, chk_vld_d;  // read data of the previous cycle is to be checked
  logic        hit_q, hit_d;
  logic        m_tvalid_q, m_tvalid_d;
  logic [1:0]  op_q;
  logic [63:0] key_q;                 // file offset or address relative to the image base
  logic [31:0] delta_q;
  sat_entry_t  ent_q;
  logic [OUT_W-1:0] m_tdata_q;

  logic in_acc;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Relative address and the below-base check, taken when the word is accepted.
  logic [64:0] rel_diff;
  logic        below_base;
  assign rel_diff   = {1'b0, in_address} - {1'b0, image_base_q};
  assign below_base = rel_diff[64];

  // Section table. A load writes its entry in the accept cycle; since one word is handled
  // at a time, no read of the same entry can be in flight then.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [AW+3:0]    widx_ext;
  logic [AW+4:0]    ridx_ext;

  assign widx_ext  = {{AW{1'b0}}, in_entry_index};
  assign ridx_ext  = {{AW{1'b0}}, rd_idx_q};
  assign ram_waddr = widx_ext[AW-1:0];
  assign ram_raddr = ridx_ext[AW-1:0];
  assign ram_we    = in_acc && (in_cmd == CMD_LOAD) && (32'(in_entry_index) < MAX_SECTIONS);

  sat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SECTIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Range check of the entry read in the previous cycle. An offset query matches the raw
  // range in the file, an address query the virtual range; an empty range never matches,
  // which for an offset query also skips sections with no raw data.
  sat_entry_t  rd_ent;
  logic [31:0] rng_lo;
  logic [31:0] rng_len;
  logic [32:0] rng_hi;
  logic        hit_now;
  logic [31:0] delta_now;

  assign rd_ent = sat_entry_t'(ram_rdata);

  always_comb begin
    if (op_q == CMD_OFFSET) begin
      rng_lo  = rd_ent.fptr;
      rng_len = rd_ent.fsize;
    end else begin
      rng_lo  = rd_ent.vaddr;
      rng_len = rd_ent.vsize;
    end
  end

  assign rng_hi    = {1'b0, rng_lo} + {1'b0, rng_len};
  assign hit_now   = (state_q == S_SCAN) && chk_vld_q &&
                     (key_q >= 64'(rng_lo)) && (key_q < 64'(rng_hi));
  assign delta_now = key_q[31:0] - rng_lo;
  assign ram_re    = (state_q == S_SCAN) && (rd_idx_q < n_used) && !hit_now;

  // Result of the finished word.
  logic [1:0]  res_status;
  logic [63:0] res_value;
  logic        out_free;

  always_comb begin
    res_status = STAT_MISS;
    res_value  = '0;
    case (op_q)
      CMD_LOAD: begin
        res_status = STAT_LOADED;
      end
      CMD_OFFSET: begin
        if (hit_q) begin
          res_status = STAT_OK;
          res_value  = image_base_q + 64'(ent_q.vaddr) + 64'(delta_q);
        end
      end
      CMD_ADDR: begin
        if (hit_q) begin
          if (delta_q >= ent_q.fsize) begin
            res_status = STAT_TAIL;
          end else begin
            res_status = STAT_OK;
            res_value  = 64'(ent_q.fptr) + 64'(delta_q);
          end
        end
      end
      default: begin
        res_status = STAT_MISS;
      end
    endcase
  end

  assign out_free = !m_tvalid_q || m_axis_tready_i;

  // Control next state.
  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    chk_vld_d  = chk_vld_q;
    hit_d      = hit_q;
    m_tvalid_d = m_tvalid_q;

    if (m_axis_tready_i) begin
      m_tvalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rd_idx_d  = '0;
          chk_vld_d = 1'b0;
          hit_d     = 1'b0;
          case (in_cmd)
            CMD_OFFSET: state_d = S_SCAN;
            CMD_ADDR:   state_d = below_base ? S_FORM : S_SCAN;
            default:    state_d = S_FORM;
          endcase
        end
      end
      S_SCAN: begin
        rd_idx_d  = rd_idx_q + 5'(ram_re);
        chk_vld_d = ram_re;
        if (hit_now) begin
          hit_d   = 1'b1;
          state_d = S_FORM;
        end else if (!chk_vld_q && !(rd_idx_q < n_used)) begin
          state_d = S_FORM;
        end
      end
      S_FORM: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_idx_q   <= '0;
      chk_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      chk_vld_q  <= chk_vld_d;
      hit_q      <= hit_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= in_cmd;
      if (in_cmd == CMD_OFFSET) begin
        key_q <= 64'(in_foff);
      end else begin
        key_q <= rel_diff[63:0];
      end
    end
    if (hit_now) begin
      delta_q <= delta_now;
      ent_q   <= rd_ent;
    end
    if (state_q == S_FORM && out_free) begin
      m_tdata_q <= {6'b0, res_value, res_status};
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  // Checked data always comes from a read issued in the cycle before.
  a_chk_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && chk_vld_q) |-> $past(ram_re))
    else $error("table data checked without a preceding read");

  // A load goes straight to result forming.
  a_load_to_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_cmd == CMD_LOAD) |=> (state_q == S_FORM))
    else $error("load word did not go to result forming");

  // A new result appears only after result forming.
  a_result_from_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> ($past(state_q) == S_FORM))
    else $error("result raised outside result forming");

  // The table is written only when a word is taken in the idle state.
  a_write_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE && s_axis_tvalid_i))
    else $error("table written outside word acceptance");

endmodule

### rtl/sat_ram.sv
`timescale 1ns / 1ps

module sat_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
